[src/gsoec_pkg.sv]
// shared types and codes for the gene-set overlap exceed counter
package gsoec_pkg;

   // request codes carried in the req_type field
   typedef enum logic [2:0] {
      REQ_CLEAR = 3'd0,
      REQ_ADD   = 3'd1,
      REQ_PROBE = 3'd2,
      REQ_CLOSE = 3'd3,
      REQ_READ  = 3'd4
   } req_code_type;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [14:0] gene_id;
      logic [11:0] category;
      logic [16:0] baseline;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] category_out;
      logic        exceeded;
      logic [31:0] exceed_total;
      logic [15:0] hits;
      logic [15:0] targets;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
      logic sweep;
      logic sweep_all;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic commit_ok;
      logic sweep_done;
   } dp_status_type;

endpackage

[src/gene_set_overlap_exceed_counter.sv]
// top level of the gene-set overlap exceed counter
// Usage: requests arrive on req_valid/req_stall/req_payload, one transfer per
// item; close and read items return one result on rsp_valid/rsp_stall/
// rsp_payload, other items return nothing.
// Steps: an add, probe, close or read item passes through capture, memory
// lookup plus multiply, and update, and req_stall stays high until its update
// step is done; rsp_valid comes from the output register that update loads.
// The bitmap and counter table are single-port memories; the clear item walks
// the bitmap one entry per cycle and holds req_stall high until the walk ends.
// Reset: after reset the block sweeps both memories for
// max(GENE_SLOTS, CATEGORY_SLOTS) cycles (32768 by default) with req_stall
// high; after that the bitmap, counts and all counters are zero.
// Stalls: a held result sits in the output register while rsp_stall is high;
// the next request is still taken, and only a close or read item waits in
// its update step until the output register is free.
module gene_set_overlap_exceed_counter import gsoec_pkg::*; #(
   parameter int GENE_SLOTS     = 32768,
   parameter int CATEGORY_SLOTS = 4096,
   parameter int COUNTER_BITS   = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   gsoec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_code  (req_payload.req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   gsoec_datapath #(
      .GENE_SLOTS     (GENE_SLOTS),
      .CATEGORY_SLOTS (CATEGORY_SLOTS),
      .COUNTER_BITS   (COUNTER_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/gsoec_datapath.sv]
// datapath: target bitmap, counter table, counts, overlap test and result register
module gsoec_datapath import gsoec_pkg::*; #(
   parameter int GENE_SLOTS     = 32768,
   parameter int CATEGORY_SLOTS = 4096,
   parameter int COUNTER_BITS   = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int GI_W   = $clog2(GENE_SLOTS);
   localparam int CI_W   = $clog2(CATEGORY_SLOTS);
   localparam int MAX_SLOTS = (GENE_SLOTS > CATEGORY_SLOTS) ? GENE_SLOTS : CATEGORY_SLOTS;
   localparam int SW     = $clog2(MAX_SLOTS);
   localparam int GX_W   = (GI_W > 15) ? GI_W : 15;
   localparam int CX_W   = (CI_W > 12) ? CI_W : 12;
   localparam int CW     = COUNTER_BITS;
   localparam int EXT_W  = (CW > 32) ? CW : 33;

   logic                bitmap_mem [GENE_SLOTS];
   logic [CW-1:0]       counter_mem [CATEGORY_SLOTS];

   req_payload_type     item_ff;
   logic                bit_q_ff;
   logic [CW-1:0]       cnt_q_ff;
   logic [32:0]         product_ff, product_in;
   logic [15:0]         target_count_ff, target_count_in;
   logic [15:0]         hit_count_ff, hit_count_in;
   logic [SW-1:0]       sweep_ff, sweep_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic [GX_W-1:0]     gene_x;
   logic [CX_W-1:0]     cat_x;
   logic [GI_W-1:0]     gene_idx;
   logic [CI_W-1:0]     cat_idx;
   logic                gene_ok, cat_ok;
   logic                is_add, is_probe, is_close, is_read;
   logic                out_free;
   logic                sweep_gene_ok, sweep_cat_ok;
   logic [32:0]         lhs;
   logic                exc;
   logic [CW-1:0]       cnt_new;
   logic [EXT_W-1:0]    cnt_ext;
   logic [31:0]         cnt_report;
   logic                bit_we, bit_wd, cnt_we;
   logic [GI_W-1:0]     bit_wa;
   logic [CI_W-1:0]     cnt_wa;
   logic [CW-1:0]       cnt_wd;
   logic [SW-1:0]       sweep_last;

   assign gene_x   = GX_W'(item_ff.gene_id);
   assign cat_x    = CX_W'(item_ff.category);
   assign gene_idx = gene_x[GI_W-1:0];
   assign cat_idx  = cat_x[CI_W-1:0];
   assign gene_ok  = {2'b00, item_ff.gene_id} < 17'(GENE_SLOTS);
   assign cat_ok   = {5'b00000, item_ff.category} < 17'(CATEGORY_SLOTS);

   assign is_add   = item_ff.req_type == REQ_ADD;
   assign is_probe = item_ff.req_type == REQ_PROBE;
   assign is_close = item_ff.req_type == REQ_CLOSE;
   assign is_read  = item_ff.req_type == REQ_READ;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sweep_gene_ok = {1'b0, sweep_ff} < (SW+1)'(GENE_SLOTS);
   assign sweep_cat_ok  = {1'b0, sweep_ff} < (SW+1)'(CATEGORY_SLOTS);
   assign sweep_last    = cmd.sweep_all ? SW'(MAX_SLOTS - 1) : SW'(GENE_SLOTS - 1);

   assign status.commit_ok  = !(is_close || is_read) || out_free;
   assign status.sweep_done = sweep_ff == sweep_last;

   // overlap test: targets nonzero and hits * 2^16 >= baseline * targets
   assign product_in = 33'(item_ff.baseline) * 33'(target_count_ff);
   assign lhs        = {1'b0, hit_count_ff, 16'h0000};
   assign exc        = (target_count_ff != 16'd0) && (lhs >= product_ff);

   always_comb begin
      cnt_new = cnt_q_ff;
      if (is_close && exc && cat_ok && (cnt_q_ff != {CW{1'b1}})) begin
         cnt_new = cnt_q_ff + CW'(1);
      end
      cnt_ext    = EXT_W'(cnt_new);
      cnt_report = (|cnt_ext[EXT_W-1:32]) ? TOTAL_MAX : cnt_ext[31:0];
   end

   // memory write selection
   always_comb begin
      bit_we = 1'b0;
      bit_wd = 1'b0;
      bit_wa = gene_idx;
      cnt_we = 1'b0;
      cnt_wd = cnt_new;
      cnt_wa = cat_idx;
      if (cmd.sweep) begin
         bit_we = sweep_gene_ok;
         bit_wa = GI_W'(sweep_ff);
         cnt_we = cmd.sweep_all && sweep_cat_ok;
         cnt_wa = CI_W'(sweep_ff);
         cnt_wd = '0;
      end else if (cmd.commit) begin
         bit_we = is_add && gene_ok && !bit_q_ff;
         bit_wd = 1'b1;
         cnt_we = is_close && cat_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (bit_we) begin
         bitmap_mem[bit_wa] <= bit_wd;
      end
      if (cmd.lookup) begin
         bit_q_ff <= bitmap_mem[gene_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         counter_mem[cnt_wa] <= cnt_wd;
      end
      if (cmd.lookup) begin
         cnt_q_ff <= counter_mem[cat_idx];
      end
   end

   always_comb begin
      target_count_in = target_count_ff;
      hit_count_in    = hit_count_ff;
      if (cmd.sweep && !cmd.sweep_all) begin
         target_count_in = 16'd0;
         hit_count_in    = 16'd0;
      end else if (cmd.commit) begin
         if (is_add && gene_ok && !bit_q_ff && (target_count_ff != COUNT_MAX)) begin
            target_count_in = target_count_ff + 16'd1;
         end
         if (is_probe && gene_ok && bit_q_ff && (hit_count_ff != COUNT_MAX)) begin
            hit_count_in = hit_count_ff + 16'd1;
         end
         if (is_close) begin
            hit_count_in = 16'd0;
         end
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = status.sweep_done ? '0 : sweep_ff + SW'(1);
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit && (is_close || is_read)) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.category_out = item_ff.category;
         rsp_payload_in.exceeded     = is_close && exc;
         rsp_payload_in.exceed_total = cat_ok ? cnt_report : 32'd0;
         rsp_payload_in.hits         = is_close ? hit_count_ff : 16'd0;
         rsp_payload_in.targets      = is_close ? target_count_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= 16'd0;
         hit_count_ff    <= 16'd0;
         sweep_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         target_count_ff <= target_count_in;
         hit_count_ff    <= hit_count_in;
         sweep_ff        <= sweep_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.lookup) begin
         product_ff <= product_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[src/gsoec_ctrl.sv]
// controller: sequences sweep, lookup and update steps of each item
module gsoec_ctrl import gsoec_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_code,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_LOOKUP,
      S_UPDATE,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.sweep     = 1'b1;
            cmd.sweep_all = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_code)
                  REQ_CLEAR: state_in = S_CLEAR;
                  REQ_ADD, REQ_PROBE, REQ_CLOSE, REQ_READ: state_in = S_LOOKUP;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            // results wait here until the output register can take them
            if (status.commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
